// ===== hdl/kwm_pkg.sv =====
// Package for the k-way sorted merge block: sizes, operation and status codes,
// and the structure that the head selection tree returns.
// Used by kwm_min_tree and k_way_sorted_merge; depends on nothing.
package kwm_pkg;

  // Number of lists and the capacity of each list.
  localparam int NUM_LISTS  = 8;
  localparam int LIST_DEPTH = 64;

  // Derived widths.
  localparam int LIST_W    = $clog2(NUM_LISTS);
  localparam int DEPTH_W   = $clog2(LIST_DEPTH);
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W    = LIST_W + DEPTH_W;
  localparam int MEM_DEPTH = NUM_LISTS * (1 << DEPTH_W);

  // Field widths of the ports.
  localparam int OP_W     = 2;
  localparam int INDEX_W  = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_TAKE   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Outcome of the head comparison: whether any list is live, and the winner.
  typedef struct packed {
    logic              found;
    logic [LIST_W-1:0] idx;
  } pick_t;

  // One result item as held in the output register and the skid stage.
  typedef struct packed {
    logic signed [VALUE_W-1:0] merged_value;
    logic [INDEX_W-1:0]        source_list;
    logic [STATUS_W-1:0]       status;
  } res_t;

endpackage

// ===== hdl/kwm_min_tree.sv =====
// Comparison tree that picks the smallest live head among all lists.
// Ties go to the lower list index. Depends on kwm_pkg.
module kwm_min_tree (
  input  logic signed [kwm_pkg::VALUE_W-1:0] keys [kwm_pkg::NUM_LISTS],
  input  logic [kwm_pkg::NUM_LISTS-1:0]      live,
  output kwm_pkg::pick_t                     pick
);
  import kwm_pkg::*;

  localparam int LEAVES = 1 << LIST_W;
  localparam int NODES  = 2 * LEAVES;

  logic                      node_live [NODES];
  logic signed [VALUE_W-1:0] node_key  [NODES];
  logic [LIST_W-1:0]         node_idx  [NODES];

  // Heap-ordered tree: node n has children 2n and 2n+1, leaves start at LEAVES.
  always_comb begin
    logic take_left;
    take_left = 1'b0;
    for (int n = 0; n < NODES; n++) begin
      node_live[n] = 1'b0;
      node_key[n]  = '0;
      node_idx[n]  = '0;
    end
    for (int j = 0; j < LEAVES; j++) begin
      node_idx[LEAVES + j] = LIST_W'(j);
      if (j < NUM_LISTS) begin
        node_live[LEAVES + j] = live[j];
        node_key[LEAVES + j]  = keys[j];
      end
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      // The left child holds the lower indexes, so it wins a tie.
      take_left = node_live[2*n] &&
                  (!node_live[2*n+1] || (node_key[2*n] <= node_key[2*n+1]));
      if (take_left) begin
        node_live[n] = node_live[2*n];
        node_key[n]  = node_key[2*n];
        node_idx[n]  = node_idx[2*n];
      end else begin
        node_live[n] = node_live[2*n+1];
        node_key[n]  = node_key[2*n+1];
        node_idx[n]  = node_idx[2*n+1];
      end
    end
    pick.found = node_live[1];
    pick.idx   = node_idx[1];
  end

endmodule

// ===== hdl/k_way_sorted_merge.sv =====
// A result is registered in the output register when its item transfers, or in the skid stage if held.
// Throughput: one item per cycle while op_stall is low; the two front values of
// every list are registered; a take with a third value refills the second next cycle.
// Reset clears all heads, tails, the refill and the output stages at once; the
// list store is not cleared and needs no clearing pass.
// Top level of the k-way sorted merge; depends on kwm_pkg and kwm_min_tree.
module k_way_sorted_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              op_valid,
  output logic                              op_stall,
  input  logic [kwm_pkg::OP_W-1:0]          operation,
  input  logic [kwm_pkg::INDEX_W-1:0]       list_index,
  input  logic signed [kwm_pkg::VALUE_W-1:0] value,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic signed [kwm_pkg::VALUE_W-1:0] merged_value,
  output logic [kwm_pkg::INDEX_W-1:0]       source_list,
  output logic [kwm_pkg::STATUS_W-1:0]      status
);
  import kwm_pkg::*;

  // List store and its registered read port.
  logic [VALUE_W-1:0] mem [MEM_DEPTH];
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic signed [VALUE_W-1:0] rd_data;

  // Per-list pointers and the two cached front values.
  logic [CNT_W-1:0]          hp      [NUM_LISTS];
  logic [CNT_W-1:0]          hp_next [NUM_LISTS];
  logic [CNT_W-1:0]          tc      [NUM_LISTS];
  logic [CNT_W-1:0]          tc_next [NUM_LISTS];
  logic signed [VALUE_W-1:0] f0      [NUM_LISTS];
  logic signed [VALUE_W-1:0] f0_next [NUM_LISTS];
  logic signed [VALUE_W-1:0] f1      [NUM_LISTS];
  logic signed [VALUE_W-1:0] f1_next [NUM_LISTS];
  logic signed [VALUE_W-1:0] f1_eff  [NUM_LISTS];
  logic [CNT_W-1:0]          avail   [NUM_LISTS];
  logic [NUM_LISTS-1:0]      nonempty;

  // One refill read can be in flight.
  logic              pend_valid;
  logic [LIST_W-1:0] pend_list;

  // Handshake and output stages.
  logic    accept;
  res_t    res_new;
  res_t    res_q;
  res_t    sk_q;
  logic    sk_valid;
  pick_t   pick;

  // Decoded append target.
  logic [LIST_W-1:0] sel;
  logic              in_range;
  logic              app_ok;
  logic [CNT_W:0]    hp_inc;
  logic [CNT_W:0]    hp_two;

  assign accept   = op_valid && !op_stall;
  assign op_stall = sk_valid;

  // Fill level of each list, and the second front value with the refill bypass.
  always_comb begin
    for (int i = 0; i < NUM_LISTS; i++) begin
      avail[i]    = tc[i] - hp[i];
      nonempty[i] = (hp[i] != tc[i]);
      f1_eff[i]   = (pend_valid && (pend_list == LIST_W'(i))) ? rd_data : f1[i];
    end
  end

  kwm_min_tree u_min_tree (
    .keys (f0),
    .live (nonempty),
    .pick (pick)
  );

  assign sel      = LIST_W'(list_index);
  assign in_range = (32'(list_index) < NUM_LISTS);
  assign app_ok   = in_range && (tc[sel] < CNT_W'(LIST_DEPTH));
  assign hp_inc   = {1'b0, hp[pick.idx]} + (CNT_W+1)'(1);
  assign hp_two   = {1'b0, hp[pick.idx]} + (CNT_W+1)'(2);

  // Next state and the result for the item in transfer.
  always_comb begin
    for (int i = 0; i < NUM_LISTS; i++) begin
      hp_next[i] = hp[i];
      tc_next[i] = tc[i];
      f0_next[i] = f0[i];
      f1_next[i] = f1_eff[i];
    end
    wr_en   = 1'b0;
    wr_addr = {sel, tc[sel][DEPTH_W-1:0]};
    rd_en   = 1'b0;
    rd_addr = {pick.idx, hp_two[DEPTH_W-1:0]};
    res_new = '0;
    if (accept) begin
      case (operation)
        OP_APPEND: begin
          if (app_ok) begin
            wr_en        = 1'b1;
            tc_next[sel] = tc[sel] + CNT_W'(1);
            // A short list keeps the new value in its front registers too.
            if (avail[sel] == CNT_W'(0)) begin
              f0_next[sel] = value;
            end else if (avail[sel] == CNT_W'(1)) begin
              f1_next[sel] = value;
            end
          end else begin
            res_new.status = ST_FULL;
          end
        end
        OP_TAKE: begin
          if (!pick.found) begin
            res_new.status = ST_EMPTY;
          end else begin
            res_new.merged_value = f0[pick.idx];
            res_new.source_list  = INDEX_W'(pick.idx);
            if (hp_inc >= {1'b0, tc[pick.idx]}) begin
              // The list drained, so its slots start over.
              hp_next[pick.idx] = '0;
              tc_next[pick.idx] = '0;
            end else begin
              hp_next[pick.idx] = hp_inc[CNT_W-1:0];
              f0_next[pick.idx] = f1_eff[pick.idx];
              // Fetch the value that becomes the new second front entry.
              if (hp_two < {1'b0, tc[pick.idx]}) begin
                rd_en = 1'b1;
              end
            end
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_LISTS; i++) begin
            hp_next[i] = '0;
            tc_next[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // List store write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Pointers and the refill tracker.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        hp[i] <= '0;
        tc[i] <= '0;
      end
      pend_valid <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        hp[i] <= hp_next[i];
        tc[i] <= tc_next[i];
      end
      pend_valid <= rd_en;
    end
  end

  // Front value registers and the refill list need no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LISTS; i++) begin
      f0[i] <= f0_next[i];
      f1[i] <= f1_next[i];
    end
    if (rd_en) begin
      pend_list <= pick.idx;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (sk_valid) begin
        res_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        res_valid <= accept;
      end
    end else if (accept) begin
      sk_valid <= 1'b1;
    end
  end

  // Result payloads follow the same moves as the valid bits.
  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      if (sk_valid) begin
        res_q <= sk_q;
      end else if (accept) begin
        res_q <= res_new;
      end
    end else if (accept) begin
      sk_q <= res_new;
    end
  end

  assign merged_value = res_q.merged_value;
  assign source_list  = res_q.source_list;
  assign status       = res_q.status;

`ifndef SYNTHESIS
  // The skid stage only fills behind a held result.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> res_valid)
    else $error("skid stage holds a transfer while the output register is empty");

  // A refill in flight always targets a list with at least two values left.
  a_refill_needed: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> ((tc[pend_list] - hp[pend_list]) >= CNT_W'(2)))
    else $error("refill landed for a list without a second entry");

  // A refill read is only issued by a take that found a list.
  a_refill_from_take: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (accept && (operation == OP_TAKE) && pick.found))
    else $error("list store read without a successful take");

  // Only a successful take reports a nonzero value or source.
  a_result_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status != ST_OK)) |-> ((merged_value == '0) && (source_list == '0)))
    else $error("failed operation carries a value");
`endif

endmodule
